// ===== sv/gsm_pkg.sv =====
// Shared types and constants for the generational slot map.
// No dependencies; imported by gsm_free_fifo, generational_slot_map_unit, the checker and the test.
package gsm_pkg;

  localparam int SLOT_COUNT = 4096;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int GEN_W      = 8;
  localparam int CNT_W      = SLOT_W + 1;

  localparam logic [CNT_W-1:0] REUSE_RESET = CNT_W'(1024);

  // opcodes
  localparam logic [1:0] OP_CREATE     = 2'd0;
  localparam logic [1:0] OP_REMOVE_HND = 2'd1;
  localparam logic [1:0] OP_REMOVE_POS = 2'd2;
  localparam logic [1:0] OP_LOOKUP     = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SLOT  = 2'd1;
  localparam logic [1:0] ST_NOT_LIVE = 2'd2;
  localparam logic [1:0] ST_BAD_POS  = 2'd3;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [GEN_W-1:0]  gen;
  } handle_t;

  typedef struct packed {
    logic live;
    logic [GEN_W-1:0] gen;
  } slot_rec_t;

  typedef struct packed {
    logic              push;
    logic              pop;
    logic [SLOT_W-1:0] push_slot;
  } fifo_ctrl_t;

endpackage

// ===== sv/gsm_free_fifo.sv =====
// Free-slot queue: circular buffer memory with head, tail and occupancy count.
// Depends on gsm_pkg.
module gsm_free_fifo (
  input  logic                      clk,
  input  logic                      rst_n,
  input  gsm_pkg::fifo_ctrl_t       ctrl,
  output logic [gsm_pkg::SLOT_W-1:0] head_slot,
  output logic [gsm_pkg::CNT_W-1:0]  count
);
  import gsm_pkg::*;

  logic [SLOT_W-1:0] mem [SLOT_COUNT];
  logic [SLOT_W-1:0] head_r, head_nxt;
  logic [SLOT_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  // advance pointers on push and pop
  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (ctrl.push && (count_r < CNT_W'(SLOT_COUNT))) begin
      tail_nxt  = tail_r + 1'b1;
      count_nxt = count_nxt + 1'b1;
    end
    if (ctrl.pop) begin
      head_nxt  = head_r + 1'b1;
      count_nxt = count_nxt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  // store pushed slot, read the head entry every cycle
  always_ff @(posedge clk) begin
    if (ctrl.push && (count_r < CNT_W'(SLOT_COUNT))) begin
      mem[tail_r] <= ctrl.push_slot;
    end
    head_slot <= mem[head_r];
  end

  assign count = count_r;

endmodule

// ===== sv/generational_slot_map_unit.sv =====
// Top level of the generational slot map: sequencer plus slot and dense memories.
// Depends on gsm_pkg and gsm_free_fifo.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one operation: create, remove by
//   handle, remove by dense position or lookup. The block raises in_stall while
//   an operation is in flight, so it works on one item at a time.
//   Result channel (out_valid / out_stall) returns exactly one result per item.
//   A finished result sits in an output register; the next item is accepted
//   while that result still waits for the receiver.
//   Steps after transfer, one memory read each: decode; a create with no slot or a
//   bad position then finishes; a fresh create writes; a lookup or dead handle reads
//   the slot; a reused create pops, reads the generation, writes; a remove reads the
//   slot (by handle), reads dense twice, writes. The next item is taken after the load.
//   When the receiver stalls, the finished item holds in its final step and
//   no further item is taken until the result moves into the output register.
//   Configuration (cfg_valid / cfg_ready) writes min_free_before_reuse; ready
//   is always high. Reset (rst_n, synchronous) empties the map at once: slots
//   not yet handed out read as dead through the fresh-slot count, so no
//   clearing pass is needed.
module generational_slot_map_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_opcode,
  input  logic [gsm_pkg::SLOT_W-1:0] in_slot_index,
  input  logic [gsm_pkg::GEN_W-1:0]  in_handle_generation,
  input  logic [gsm_pkg::SLOT_W-1:0] in_dense_position,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 out_status,
  output logic [gsm_pkg::SLOT_W-1:0] out_slot,
  output logic [gsm_pkg::GEN_W-1:0]  out_generation,
  output logic [gsm_pkg::SLOT_W-1:0] out_position,
  output logic [gsm_pkg::CNT_W-1:0]  out_live_count,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [gsm_pkg::CNT_W-1:0]  cfg_min_free_before_reuse
);
  import gsm_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DEC  = 4'd1;
  localparam logic [3:0] S_RF   = 4'd2;
  localparam logic [3:0] S_RG   = 4'd3;
  localparam logic [3:0] S_WC   = 4'd4;
  localparam logic [3:0] S_RS   = 4'd5;
  localparam logic [3:0] S_RD0  = 4'd6;
  localparam logic [3:0] S_RD1  = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  logic [3:0]        state_r, state_nxt;
  logic [1:0]        op_r, op_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [GEN_W-1:0]  gen_r, gen_nxt;
  logic [SLOT_W-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0]  fresh_next_r, fresh_next_nxt;
  logic [CNT_W-1:0]  live_total_r, live_total_nxt;
  logic [CNT_W-1:0]  min_free_r;
  handle_t           h_r, h_nxt;
  logic [1:0]        res_status_r, res_status_nxt;
  logic [SLOT_W-1:0] res_slot_r, res_slot_nxt;
  logic [GEN_W-1:0]  res_gen_r, res_gen_nxt;
  logic [SLOT_W-1:0] res_pos_r, res_pos_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_status_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic [GEN_W-1:0]  out_gen_r;
  logic [SLOT_W-1:0] out_pos_r;
  logic [CNT_W-1:0]  out_live_r;
  logic              out_load;

  // memories
  slot_rec_t         slot_mem [SLOT_COUNT];
  logic [SLOT_W-1:0] s2d_mem  [SLOT_COUNT];
  handle_t           dense_mem[SLOT_COUNT];

  slot_rec_t         a_q, a_wdata;
  logic              a_we;
  logic [SLOT_W-1:0] a_waddr, a_raddr;
  logic [SLOT_W-1:0] b_q, b_wdata, b_waddr;
  logic              b_we;
  handle_t           d_q, d_wdata;
  logic              d_we;
  logic [SLOT_W-1:0] d_waddr, d_raddr;

  fifo_ctrl_t        fctl;
  logic [SLOT_W-1:0] fifo_head;
  logic [CNT_W-1:0]  free_count;

  logic              reuse;
  logic              alive;
  logic [SLOT_W-1:0] last_pos;

  gsm_free_fifo u_free (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (fctl),
    .head_slot (fifo_head),
    .count     (free_count)
  );

  assign reuse    = (free_count > min_free_r) || (fresh_next_r >= CNT_W'(SLOT_COUNT));
  assign alive    = ({1'b0, slot_r} < fresh_next_r) && a_q.live && (a_q.gen == gen_r);
  assign last_pos = SLOT_W'(live_total_r - 1'b1);
  assign out_load = (state_r == S_FIN) && (!out_valid_r || !out_stall);

  // read addresses follow the step
  assign a_raddr = (state_r == S_RF) ? fifo_head : slot_r;
  always_comb begin
    unique case (state_r)
      S_RS:    d_raddr = b_q;
      S_RD0:   d_raddr = last_pos;
      default: d_raddr = pos_r;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    slot_nxt       = slot_r;
    gen_nxt        = gen_r;
    pos_nxt        = pos_r;
    fresh_next_nxt = fresh_next_r;
    live_total_nxt = live_total_r;
    h_nxt          = h_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_gen_nxt    = res_gen_r;
    res_pos_nxt    = res_pos_r;
    a_we = 1'b0; a_waddr = res_slot_r; a_wdata = '{live: 1'b1, gen: res_gen_r};
    b_we = 1'b0; b_waddr = res_slot_r; b_wdata = SLOT_W'(live_total_r);
    d_we = 1'b0; d_waddr = SLOT_W'(live_total_r);
    d_wdata = '{slot: res_slot_r, gen: res_gen_r};
    fctl = '{push: 1'b0, pop: 1'b0, push_slot: h_r.slot};

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt         = in_opcode;
          slot_nxt       = in_slot_index;
          gen_nxt        = in_handle_generation;
          pos_nxt        = in_dense_position;
          res_status_nxt = ST_OK;
          res_slot_nxt   = '0;
          res_gen_nxt    = '0;
          res_pos_nxt    = '0;
          state_nxt      = S_DEC;
        end
      end
      S_DEC: begin
        unique case (op_r)
          OP_CREATE: begin
            if (reuse) begin
              if (free_count == '0) begin
                res_status_nxt = ST_NO_SLOT;
                state_nxt      = S_FIN;
              end else begin
                state_nxt = S_RF;
              end
            end else begin
              res_slot_nxt   = SLOT_W'(fresh_next_r);
              res_gen_nxt    = '0;
              fresh_next_nxt = fresh_next_r + 1'b1;
              state_nxt      = S_WC;
            end
          end
          OP_REMOVE_POS: begin
            if ({1'b0, pos_r} >= live_total_r) begin
              res_status_nxt = ST_BAD_POS;
              state_nxt      = S_FIN;
            end else begin
              state_nxt = S_RD0;
            end
          end
          default: state_nxt = S_RS;
        endcase
      end
      S_RF: begin
        // pop the oldest freed slot, its generation reads next
        res_slot_nxt = fifo_head;
        fctl.pop     = 1'b1;
        state_nxt    = S_RG;
      end
      S_RG: begin
        res_gen_nxt = a_q.gen;
        state_nxt   = S_WC;
      end
      S_WC: begin
        // append the new handle to the dense list
        a_we           = 1'b1;
        b_we           = 1'b1;
        d_we           = 1'b1;
        res_pos_nxt    = SLOT_W'(live_total_r);
        live_total_nxt = live_total_r + 1'b1;
        state_nxt      = S_FIN;
      end
      S_RS: begin
        if (!alive || ((op_r == OP_REMOVE_HND) && ({1'b0, b_q} >= live_total_r))) begin
          res_status_nxt = ST_NOT_LIVE;
          state_nxt      = S_FIN;
        end else if (op_r == OP_LOOKUP) begin
          res_slot_nxt = slot_r;
          res_gen_nxt  = gen_r;
          res_pos_nxt  = b_q;
          state_nxt    = S_FIN;
        end else begin
          pos_nxt   = b_q;
          state_nxt = S_RD0;
        end
      end
      S_RD0: begin
        h_nxt     = d_q;
        state_nxt = S_RD1;
      end
      S_RD1: begin
        // move the last entry into the hole, retire the removed slot
        if (pos_r != last_pos) begin
          d_we    = 1'b1;
          d_waddr = pos_r;
          d_wdata = d_q;
          b_we    = 1'b1;
          b_waddr = d_q.slot;
          b_wdata = pos_r;
        end
        a_we           = 1'b1;
        a_waddr        = h_r.slot;
        a_wdata        = '{live: 1'b0, gen: h_r.gen + 1'b1};
        fctl.push      = 1'b1;
        live_total_nxt = live_total_r - 1'b1;
        res_slot_nxt   = h_r.slot;
        res_gen_nxt    = h_r.gen;
        res_pos_nxt    = pos_r;
        state_nxt      = S_FIN;
      end
      S_FIN: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (out_load) out_valid_nxt = 1'b1;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      fresh_next_r <= '0;
      live_total_r <= '0;
      min_free_r   <= REUSE_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fresh_next_r <= fresh_next_nxt;
      live_total_r <= live_total_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_valid) min_free_r <= cfg_min_free_before_reuse;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    slot_r       <= slot_nxt;
    gen_r        <= gen_nxt;
    pos_r        <= pos_nxt;
    h_r          <= h_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_gen_r    <= res_gen_nxt;
    res_pos_r    <= res_pos_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_slot_r   <= res_slot_r;
      out_gen_r    <= res_gen_r;
      out_pos_r    <= res_pos_r;
      out_live_r   <= live_total_r;
    end
  end

  // slot record, slot-to-dense and dense list memories
  always_ff @(posedge clk) begin
    if (a_we) slot_mem[a_waddr] <= a_wdata;
    a_q <= slot_mem[a_raddr];
  end

  always_ff @(posedge clk) begin
    if (b_we) s2d_mem[b_waddr] <= b_wdata;
    b_q <= s2d_mem[slot_r];
  end

  always_ff @(posedge clk) begin
    if (d_we) dense_mem[d_waddr] <= d_wdata;
    d_q <= dense_mem[d_raddr];
  end

  assign in_stall       = (state_r != S_IDLE);
  assign cfg_ready      = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_slot       = out_slot_r;
  assign out_generation = out_gen_r;
  assign out_position   = out_pos_r;
  assign out_live_count = out_live_r;

endmodule

// ===== bench/generational_slot_map_unit_checker.sv =====
// Checker for the generational slot map: watches the operation, result and
// register channels, predicts each result and compares it. Depends on gsm_pkg.
`timescale 1ns / 100ps

module generational_slot_map_unit_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [1:0]                 in_opcode,
  input  logic [gsm_pkg::SLOT_W-1:0] in_slot_index,
  input  logic [gsm_pkg::GEN_W-1:0]  in_handle_generation,
  input  logic [gsm_pkg::SLOT_W-1:0] in_dense_position,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [1:0]                 out_status,
  input  logic [gsm_pkg::SLOT_W-1:0] out_slot,
  input  logic [gsm_pkg::GEN_W-1:0]  out_generation,
  input  logic [gsm_pkg::SLOT_W-1:0] out_position,
  input  logic [gsm_pkg::CNT_W-1:0]  out_live_count,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [gsm_pkg::CNT_W-1:0]  cfg_min_free_before_reuse,
  output int                         fail_count,
  output int                         pending_results,
  output int                         live_handles
);
  import gsm_pkg::*;

  localparam int EXP_DEPTH = 8;

  typedef struct packed {
    logic [1:0]        status;
    logic [SLOT_W-1:0] slot;
    logic [GEN_W-1:0]  gen;
    logic [SLOT_W-1:0] pos;
    logic [CNT_W-1:0]  live;
  } map_result_t;

  // shadow of the map state
  logic [GEN_W-1:0]  gen_mem   [SLOT_COUNT];
  logic [SLOT_W-1:0] dense_of  [SLOT_COUNT];
  logic              alive     [SLOT_COUNT];
  handle_t           dense_list[SLOT_COUNT];
  logic [SLOT_W-1:0] freed_mem [SLOT_COUNT];
  int                freed_head;
  int                freed_tail;
  int                freed_cnt;
  int                fresh_cnt;
  int                live_cnt;
  logic [CNT_W-1:0]  reuse_floor;
  map_result_t       exp_mem[EXP_DEPTH];
  int                exp_wr;
  int                exp_rd;

  assign pending_results = exp_wr - exp_rd;
  assign live_handles    = live_cnt;

  function automatic logic handle_is_live(logic [SLOT_W-1:0] s, logic [GEN_W-1:0] g);
    return alive[s] && gen_mem[s] == g;
  endfunction

  // pull dense entry p out, back-fill from the tail, retire its slot
  function automatic map_result_t remove_entry(int p);
    map_result_t r;
    handle_t     h;
    handle_t     m;
    h = dense_list[p];
    if (p != live_cnt - 1) begin
      m = dense_list[live_cnt-1];
      dense_list[p] = m;
      dense_of[m.slot] = SLOT_W'(p);
    end
    live_cnt--;
    r = '0;
    r.slot = h.slot;
    r.gen  = h.gen;
    r.pos  = SLOT_W'(p);
    alive[h.slot] = 1'b0;
    gen_mem[h.slot] = gen_mem[h.slot] + 1'b1;
    if (freed_cnt < SLOT_COUNT) begin
      freed_mem[freed_tail] = h.slot;
      freed_tail = (freed_tail + 1) % SLOT_COUNT;
      freed_cnt++;
    end
    return r;
  endfunction

  function automatic map_result_t apply_map_op(logic [1:0] op, logic [SLOT_W-1:0] s,
                                               logic [GEN_W-1:0] g, logic [SLOT_W-1:0] p);
    map_result_t r;
    logic [SLOT_W-1:0] ns;
    logic have;
    r = '0;
    case (op)
      OP_CREATE: begin
        have = 1'b1;
        ns = '0;
        if (freed_cnt > int'(reuse_floor) || fresh_cnt >= SLOT_COUNT) begin
          if (freed_cnt == 0) begin
            have = 1'b0;
          end else begin
            ns = freed_mem[freed_head];
            freed_head = (freed_head + 1) % SLOT_COUNT;
            freed_cnt--;
          end
        end else begin
          ns = SLOT_W'(fresh_cnt);
          gen_mem[ns] = '0;
          fresh_cnt++;
        end
        if (!have || live_cnt >= SLOT_COUNT) begin
          r.status = ST_NO_SLOT;
        end else begin
          dense_list[live_cnt] = '{slot: ns, gen: gen_mem[ns]};
          dense_of[ns] = SLOT_W'(live_cnt);
          alive[ns] = 1'b1;
          r.slot = ns;
          r.gen  = gen_mem[ns];
          r.pos  = SLOT_W'(live_cnt);
          live_cnt++;
        end
      end
      OP_REMOVE_HND: begin
        if (!handle_is_live(s, g) || dense_of[s] >= live_cnt) r.status = ST_NOT_LIVE;
        else r = remove_entry(int'(dense_of[s]));
      end
      OP_REMOVE_POS: begin
        if (p >= live_cnt) r.status = ST_BAD_POS;
        else r = remove_entry(int'(p));
      end
      default: begin
        if (!handle_is_live(s, g)) begin
          r.status = ST_NOT_LIVE;
        end else begin
          r.slot = s;
          r.gen  = g;
          r.pos  = dense_of[s];
        end
      end
    endcase
    r.live = CNT_W'(live_cnt);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t: result %s mismatch: got %0d, want %0d", $time, what, got, want);
    fail_count++;
  endtask

  // predict on each operation transfer, compare on each result transfer
  always @(posedge clk) begin
    map_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < SLOT_COUNT; i++) alive[i] = 1'b0;
      freed_head = 0;
      freed_tail = 0;
      freed_cnt = 0;
      exp_wr = 0;
      exp_rd = 0;
      fresh_cnt = 0;
      live_cnt = 0;
      reuse_floor = REUSE_RESET;
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) reuse_floor = cfg_min_free_before_reuse;
      if (in_valid && !in_stall) begin
        if (exp_wr - exp_rd >= EXP_DEPTH) begin
          $display("%0t: too many results outstanding", $time);
          fail_count++;
        end
        exp_mem[exp_wr % EXP_DEPTH] = apply_map_op(in_opcode, in_slot_index,
                                                   in_handle_generation, in_dense_position);
        exp_wr++;
      end
      if (out_valid && !out_stall) begin
        if (exp_wr == exp_rd) begin
          $display("%0t: result with nothing expected", $time);
          fail_count++;
        end else begin
          want = exp_mem[exp_rd % EXP_DEPTH];
          exp_rd++;
          if (out_status !== want.status) report_mismatch("status", out_status, want.status);
          if (out_slot !== want.slot) report_mismatch("slot", out_slot, want.slot);
          if (out_generation !== want.gen)
            report_mismatch("generation", out_generation, want.gen);
          if (out_position !== want.pos) report_mismatch("position", out_position, want.pos);
          if (out_live_count !== want.live)
            report_mismatch("live_count", out_live_count, want.live);
        end
      end
    end
  end

endmodule

// ===== bench/generational_slot_map_unit_test.sv =====
// Stimulus and verdict for the generational slot map unit.
// Depends on gsm_pkg, generational_slot_map_unit and its checker.
`timescale 1ns / 100ps

module generational_slot_map_unit_test;
  import gsm_pkg::*;

  localparam int IDLE_LIMIT   = 20000;
  localparam int ISSUED_DEPTH = 512;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [1:0]       in_opcode;
  logic [SLOT_W-1:0] in_slot_index;
  logic [GEN_W-1:0] in_handle_generation;
  logic [SLOT_W-1:0] in_dense_position;
  logic             out_valid;
  logic             out_stall;
  logic [1:0]       out_status;
  logic [SLOT_W-1:0] out_slot;
  logic [GEN_W-1:0] out_generation;
  logic [SLOT_W-1:0] out_position;
  logic [CNT_W-1:0] out_live_count;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_min_free_before_reuse;
  int               fail_count;
  int               pending_results;
  int               live_handles;
  int               idle_cycles;
  logic             hold_off_request;
  logic [CNT_W-1:0] reuse_floors [5];

  // handles handed out, kept for well-formed removes and lookups
  handle_t issued_mem[ISSUED_DEPTH];
  int      issued_cnt;

  generational_slot_map_unit u_dut (.*);

  generational_slot_map_unit_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // record handles from every OK result on the result channel
  always @(posedge clk) begin
    if (!rst_n) begin
      issued_cnt = 0;
    end else if (out_valid && !out_stall && out_status == ST_OK) begin
      if (issued_cnt < ISSUED_DEPTH) begin
        issued_mem[issued_cnt] = '{slot: out_slot, gen: out_generation};
        issued_cnt++;
      end else begin
        issued_mem[$urandom_range(0, ISSUED_DEPTH - 1)] = '{slot: out_slot, gen: out_generation};
      end
    end
  end

  function automatic int short_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) :
           ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 3);
  endfunction

  // receiver: random stalls, plus a long hold-off whenever one is requested
  initial begin
    int n;
    out_stall = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_off_request) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
      end
      n = short_gap();
      out_stall <= (n != 0);
      repeat (n == 0 ? $urandom_range(1, 20) : n) @(posedge clk);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("generational_slot_map_unit_test failed");
        $finish;
      end
    end
  end

  task automatic send_op(logic [1:0] op, logic [SLOT_W-1:0] s, logic [GEN_W-1:0] g,
                         logic [SLOT_W-1:0] p, bit with_gap);
    int n;
    n = with_gap ? short_gap() : 0;
    if (n != 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_slot_index <= s;
    in_handle_generation <= g;
    in_dense_position <= p;
    @(posedge clk iff !in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk iff pending_results == 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reuse_floor(logic [CNT_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_min_free_before_reuse <= v;
    @(posedge clk iff cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // one random operation, mostly well-formed
  task automatic random_op(bit with_gap);
    int k;
    handle_t h;
    k = $urandom_range(0, 99);
    if (issued_cnt != 0) h = issued_mem[$urandom_range(0, issued_cnt - 1)];
    else h = '{slot: SLOT_W'($urandom), gen: GEN_W'($urandom)};
    if (k < 40)
      send_op(OP_CREATE, SLOT_W'($urandom), GEN_W'($urandom), SLOT_W'($urandom), with_gap);
    else if (k < 60)
      send_op(OP_REMOVE_HND, h.slot, h.gen, SLOT_W'($urandom), with_gap);
    else if (k < 72)
      send_op(OP_REMOVE_POS, SLOT_W'($urandom), GEN_W'($urandom),
              SLOT_W'($urandom_range(0, live_handles + 2)), with_gap);
    else if (k < 90)
      send_op(OP_LOOKUP, h.slot, h.gen, SLOT_W'($urandom), with_gap);
    else
      send_op(2'($urandom_range(1, 3)), SLOT_W'($urandom), GEN_W'($urandom),
              SLOT_W'($urandom), with_gap);
  endtask

  initial begin
    reuse_floors = '{13'd4096, 13'd1, 13'd0, 13'd8191, 13'd3};
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = OP_CREATE;
    in_slot_index = '0;
    in_handle_generation = '0;
    in_dense_position = '0;
    cfg_valid = 1'b0;
    cfg_min_free_before_reuse = '0;
    hold_off_request = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty-map failures, field extremes, creates and removes
    write_reuse_floor('0);
    send_op(OP_REMOVE_POS, 0, 0, 0, 0);
    send_op(OP_REMOVE_POS, '1, '1, '1, 0);
    send_op(OP_REMOVE_HND, '1, '1, 0, 0);
    send_op(OP_LOOKUP, 0, 0, 0, 0);
    for (int i = 0; i < 5; i++) send_op(OP_CREATE, 0, 0, 0, 0);
    send_op(OP_LOOKUP, 4, 0, 0, 0);
    send_op(OP_LOOKUP, 4, '1, 0, 0);
    send_op(OP_LOOKUP, '1, 0, 0, 0);
    send_op(OP_REMOVE_POS, 0, 0, 1, 0);
    send_op(OP_REMOVE_POS, 0, 0, 3, 0);
    send_op(OP_REMOVE_HND, 0, 0, 0, 0);
    send_op(OP_REMOVE_HND, 0, 0, 0, 0);
    send_op(OP_CREATE, 0, 0, 0, 0);
    send_op(OP_LOOKUP, 1, 1, 0, 0);
    send_op(OP_REMOVE_POS, 0, 0, 5, 0);
    send_op(OP_REMOVE_POS, 0, 0, 0, 0);
    drain();

    // random phases across reuse thresholds, starting at the slot count
    for (int i = 0; i < 5; i++) begin
      write_reuse_floor(reuse_floors[i]);
      for (int j = 0; j < 80; j++) begin
        if (i == 1 && j == 10) hold_off_request = 1'b1;
        if (i == 1 && j == 12) hold_off_request = 1'b0;
        random_op(1);
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("generational_slot_map_unit_test passed");
    end else begin
      $display("generational_slot_map_unit_test failed");
    end
    $finish;
  end

endmodule
